FILE: rtl/grcm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// grcm_pkg
// Shared types and constants of the gain ramp channel mixer.
// ---------------------------------------------------------------------------
package grcm_pkg;

  localparam int MAX_OUTPUTS = 32;
  localparam int FRAME_BITS  = 48;
  localparam int CH_W        = 5;
  localparam int CNT_W       = 6;
  localparam int GAIN_W      = 20;
  localparam int SAMP_W      = 24;
  localparam int RAMP_W      = 20;
  localparam int PROD_W      = SAMP_W + GAIN_W;
  localparam int MAG_W       = 41;
  localparam int DIV_STEPS   = 21;
  localparam int DCNT_W      = 5;
  localparam int CFG_W       = 20;

  localparam logic [FRAME_BITS-1:0] NEVER_END = '1;

  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_ARM    = 2'd1;
  localparam logic [1:0] ACT_SAMPLE = 2'd2;
  localparam logic [1:0] ACT_NOP    = 2'd3;

  localparam logic CFG_NUM_OUTPUTS  = 1'b0;
  localparam logic CFG_DEFAULT_RAMP = 1'b1;

  typedef struct packed {
    logic [1:0]               action;
    logic [CH_W-1:0]          out_index;
    logic signed [GAIN_W-1:0] direct_gain;
    logic signed [GAIN_W-1:0] diffuse_gain;
    logic [FRAME_BITS-1:0]    start_frame;
    logic [FRAME_BITS-1:0]    end_frame;
    logic                     jump;
    logic                     ramp_given;
    logic [RAMP_W-1:0]        ramp_samples;
    logic signed [SAMP_W-1:0] sample;
  } in_beat_t;

  typedef struct packed {
    logic [CH_W-1:0]          channel;
    logic signed [SAMP_W-1:0] direct_part;
    logic signed [SAMP_W-1:0] diffuse_part;
    logic                     last;
  } out_beat_t;

  typedef struct packed {
    logic            accept;
    logic            activate;
    logic            check;
    logic            rd;
    logic            mul;
    logic            div_step;
    logic            gain;
    logic            smul;
    logic            out_load;
    logic [CH_W-1:0] k;
    logic            last;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] n;
    logic             live_blk;
    logic             ramping;
    logic             out_free;
  } stat_t;

endpackage

FILE: rtl/grcm_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// grcm_ctrl
// Sequencer: takes input beats, walks the outputs of one sample and
// steps the datapath through ramp division, scaling and output.
// ---------------------------------------------------------------------------
module grcm_ctrl
  import grcm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_action,
  output logic       in_stall,
  input  stat_t      stat,
  output cmd_t       cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ACT  = 4'd1;
  localparam logic [3:0] S_CHK  = 4'd2;
  localparam logic [3:0] S_RD   = 4'd3;
  localparam logic [3:0] S_MUL  = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_GAIN = 4'd6;
  localparam logic [3:0] S_SMUL = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0]        state_r, state_nxt;
  logic [CH_W-1:0]   k_r, k_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic              last;

  assign in_stall = (state_r != S_IDLE);
  assign last     = ({1'b0, k_r} + CNT_W'(1)) == stat.n;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    dcnt_nxt  = dcnt_r;
    cmd       = '0;
    cmd.k     = k_r;
    cmd.last  = last;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_action == ACT_SAMPLE) state_nxt = S_ACT;
        end
      end
      S_ACT: begin
        cmd.activate = 1'b1;
        state_nxt    = S_CHK;
      end
      S_CHK: begin
        cmd.check = 1'b1;
        k_nxt     = '0;
        if (stat.live_blk && stat.n != '0) state_nxt = S_RD;
        else state_nxt = S_IDLE;
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = stat.ramping ? S_MUL : S_GAIN;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        dcnt_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        dcnt_nxt     = dcnt_r + DCNT_W'(1);
        if (dcnt_r == DCNT_W'(DIV_STEPS - 1)) state_nxt = S_GAIN;
      end
      S_GAIN: begin
        cmd.gain  = 1'b1;
        state_nxt = S_SMUL;
      end
      S_SMUL: begin
        cmd.smul  = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          if (last) state_nxt = S_IDLE;
          else begin
            k_nxt     = k_r + CH_W'(1);
            state_nxt = S_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
      dcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      dcnt_r  <= dcnt_nxt;
    end
  end

endmodule

FILE: rtl/grcm_dpath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// grcm_dpath
// Gain sets, block registers, ramp divider, sample scaling and the
// output register.
// ---------------------------------------------------------------------------
module grcm_dpath
  import grcm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_idx,
  input  logic [CFG_W-1:0] cfg_data,
  input  in_beat_t         in_data,
  input  cmd_t             cmd,
  output stat_t            stat,
  input  logic             out_stall,
  output logic             out_valid,
  output out_beat_t        out_data
);

  logic [CNT_W-1:0]      num_outputs_r;
  logic [RAMP_W-1:0]     default_ramp_r;
  logic [FRAME_BITS-1:0] frame_r, t_r;
  logic signed [SAMP_W-1:0] samp_r;

  logic signed [GAIN_W-1:0] cur_d_r [MAX_OUTPUTS];
  logic signed [GAIN_W-1:0] cur_f_r [MAX_OUTPUTS];
  logic signed [GAIN_W-1:0] prv_d_r [MAX_OUTPUTS];
  logic signed [GAIN_W-1:0] prv_f_r [MAX_OUTPUTS];
  logic signed [GAIN_W-1:0] pnd_d_r [MAX_OUTPUTS];
  logic signed [GAIN_W-1:0] pnd_f_r [MAX_OUTPUTS];

  logic [FRAME_BITS-1:0] cur_start_r, cur_end_r, pnd_start_r, pnd_end_r;
  logic [RAMP_W-1:0]     cur_ramp_r, pnd_ramp_r, delta_r;
  logic                  pnd_jump_r, pnd_armed_r, seen_r, ramping_r;

  logic signed [GAIN_W-1:0] gc_d_r, gc_f_r, gp_d_r, gp_f_r, g_d_r, g_f_r;
  logic [RAMP_W-1:0]        rem_d_r, rem_f_r;
  logic [DIV_STEPS-1:0]     num_d_r, num_f_r;
  logic                     neg_d_r, neg_f_r;
  logic signed [PROD_W-1:0] prod_d_r, prod_f_r;
  logic                     out_valid_r;
  out_beat_t                out_r;

  logic                  activate_now;
  logic [FRAME_BITS-1:0] blk_len, delta_full;
  logic [RAMP_W-1:0]     new_ramp;
  logic signed [GAIN_W:0] diff_d, diff_f;
  logic [GAIN_W:0]       absd_d, absd_f;
  logic [MAG_W-1:0]      mag_d, mag_f;
  logic [RAMP_W:0]       trial_d, trial_f;
  logic                  qb_d, qb_f;
  logic signed [GAIN_W+1:0] step_d, step_f;
  logic signed [GAIN_W-1:0] cur_sat_d, cur_sat_f;

  // Status toward the sequencer.
  assign stat.n        = (num_outputs_r > CNT_W'(MAX_OUTPUTS)) ? CNT_W'(MAX_OUTPUTS)
                                                               : num_outputs_r;
  assign stat.live_blk = seen_r && (t_r >= cur_start_r) &&
                         ((cur_end_r == NEVER_END) || (t_r < cur_end_r));
  assign stat.ramping  = ramping_r;
  assign stat.out_free = !out_valid_r || !out_stall;

  // Block activation terms.
  assign activate_now = pnd_armed_r && (t_r >= pnd_start_r);
  assign blk_len      = (pnd_end_r > pnd_start_r) ? (pnd_end_r - pnd_start_r) : '0;
  always_comb begin
    if (pnd_jump_r || !seen_r) new_ramp = '0;
    else if ({{(FRAME_BITS-RAMP_W){1'b0}}, pnd_ramp_r} < blk_len) new_ramp = pnd_ramp_r;
    else new_ramp = blk_len[RAMP_W-1:0];
  end
  assign delta_full = t_r - cur_start_r;

  // Ramp numerator magnitude, rounded by half the divisor.
  assign diff_d = GAIN_W'(0) + {gc_d_r[GAIN_W-1], gc_d_r} - {gp_d_r[GAIN_W-1], gp_d_r};
  assign diff_f = GAIN_W'(0) + {gc_f_r[GAIN_W-1], gc_f_r} - {gp_f_r[GAIN_W-1], gp_f_r};
  assign absd_d = diff_d[GAIN_W] ? (GAIN_W+1)'(-diff_d) : diff_d;
  assign absd_f = diff_f[GAIN_W] ? (GAIN_W+1)'(-diff_f) : diff_f;
  assign mag_d  = MAG_W'(absd_d * delta_r) + MAG_W'(cur_ramp_r >> 1);
  assign mag_f  = MAG_W'(absd_f * delta_r) + MAG_W'(cur_ramp_r >> 1);

  // One restoring division step per cycle.
  assign trial_d = {rem_d_r, num_d_r[DIV_STEPS-1]};
  assign trial_f = {rem_f_r, num_f_r[DIV_STEPS-1]};
  assign qb_d    = trial_d >= {1'b0, cur_ramp_r};
  assign qb_f    = trial_f >= {1'b0, cur_ramp_r};

  // Signed quotient added to the previous gain.
  assign step_d = neg_d_r ? -$signed({1'b0, num_d_r}) : $signed({1'b0, num_d_r});
  assign step_f = neg_f_r ? -$signed({1'b0, num_f_r}) : $signed({1'b0, num_f_r});
  assign cur_sat_d = ramping_r ? GAIN_W'(gp_d_r + step_d) : gc_d_r;
  assign cur_sat_f = ramping_r ? GAIN_W'(gp_f_r + step_f) : gc_f_r;

  // Round half up by 16 bits and saturate to the sample range.
  function automatic logic signed [SAMP_W-1:0] scale_sat(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W:0]    ps;
    logic signed [PROD_W-16:0] r;
    ps = {p[PROD_W-1], p} + (PROD_W+1)'(32768);
    r  = ps[PROD_W:16];
    if (r > (PROD_W-15)'(8388607)) scale_sat = {1'b0, {(SAMP_W-1){1'b1}}};
    else if (r < -(PROD_W-15)'(8388608)) scale_sat = {1'b1, {(SAMP_W-1){1'b0}}};
    else scale_sat = r[SAMP_W-1:0];
  endfunction

  // Configuration, block state and gain sets.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_outputs_r  <= CNT_W'(2);
      default_ramp_r <= '0;
      frame_r        <= '0;
      cur_start_r    <= '0;
      cur_end_r      <= '0;
      cur_ramp_r     <= '0;
      pnd_start_r    <= '0;
      pnd_end_r      <= '0;
      pnd_ramp_r     <= '0;
      pnd_jump_r     <= 1'b0;
      pnd_armed_r    <= 1'b0;
      seen_r         <= 1'b0;
      for (int i = 0; i < MAX_OUTPUTS; i++) begin
        cur_d_r[i] <= '0;
        cur_f_r[i] <= '0;
        prv_d_r[i] <= '0;
        prv_f_r[i] <= '0;
        pnd_d_r[i] <= '0;
        pnd_f_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_idx == CFG_NUM_OUTPUTS) num_outputs_r <= cfg_data[CNT_W-1:0];
        else default_ramp_r <= cfg_data[RAMP_W-1:0];
      end
      if (cmd.accept) begin
        case (in_data.action)
          ACT_LOAD: begin
            pnd_d_r[in_data.out_index] <= in_data.direct_gain;
            pnd_f_r[in_data.out_index] <= in_data.diffuse_gain;
          end
          ACT_ARM: begin
            pnd_start_r <= in_data.start_frame;
            pnd_end_r   <= in_data.end_frame;
            pnd_jump_r  <= in_data.jump;
            pnd_ramp_r  <= in_data.ramp_given ? in_data.ramp_samples : default_ramp_r;
            pnd_armed_r <= 1'b1;
          end
          ACT_SAMPLE: frame_r <= frame_r + FRAME_BITS'(1);
          default: ;
        endcase
      end
      if (cmd.activate && activate_now) begin
        for (int i = 0; i < MAX_OUTPUTS; i++) begin
          prv_d_r[i] <= cur_d_r[i];
          prv_f_r[i] <= cur_f_r[i];
          cur_d_r[i] <= pnd_d_r[i];
          cur_f_r[i] <= pnd_f_r[i];
        end
        cur_start_r <= pnd_start_r;
        cur_end_r   <= pnd_end_r;
        cur_ramp_r  <= new_ramp;
        seen_r      <= 1'b1;
        pnd_armed_r <= 1'b0;
      end
    end
  end

  // Per-sample and per-output working registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      t_r    <= frame_r;
      samp_r <= in_data.sample;
    end
    if (cmd.check) begin
      delta_r   <= delta_full[RAMP_W-1:0];
      ramping_r <= (cur_ramp_r != '0) &&
                   (delta_full < {{(FRAME_BITS-RAMP_W){1'b0}}, cur_ramp_r});
    end
    if (cmd.rd) begin
      gc_d_r <= cur_d_r[cmd.k];
      gc_f_r <= cur_f_r[cmd.k];
      gp_d_r <= prv_d_r[cmd.k];
      gp_f_r <= prv_f_r[cmd.k];
    end
    if (cmd.mul) begin
      rem_d_r <= mag_d[MAG_W-1:DIV_STEPS];
      num_d_r <= mag_d[DIV_STEPS-1:0];
      neg_d_r <= diff_d[GAIN_W];
      rem_f_r <= mag_f[MAG_W-1:DIV_STEPS];
      num_f_r <= mag_f[DIV_STEPS-1:0];
      neg_f_r <= diff_f[GAIN_W];
    end
    if (cmd.div_step) begin
      rem_d_r <= qb_d ? RAMP_W'(trial_d - {1'b0, cur_ramp_r}) : trial_d[RAMP_W-1:0];
      num_d_r <= {num_d_r[DIV_STEPS-2:0], qb_d};
      rem_f_r <= qb_f ? RAMP_W'(trial_f - {1'b0, cur_ramp_r}) : trial_f[RAMP_W-1:0];
      num_f_r <= {num_f_r[DIV_STEPS-2:0], qb_f};
    end
    if (cmd.gain) begin
      g_d_r <= cur_sat_d;
      g_f_r <= cur_sat_f;
    end
    if (cmd.smul) begin
      prod_d_r <= samp_r * g_d_r;
      prod_f_r <= samp_r * g_f_r;
    end
    if (cmd.out_load) begin
      out_r.channel      <= cmd.k;
      out_r.direct_part  <= scale_sat(prod_d_r);
      out_r.diffuse_part <= scale_sat(prod_f_r);
      out_r.last         <= cmd.last;
    end
  end

  // Output beat valid.
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.out_load) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: rtl/gain_ramp_channel_mixer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gain_ramp_channel_mixer
// Fans one audio channel out to up to 32 outputs with ramped gains.
// ---------------------------------------------------------------------------
// Input beats carry a gain load, a block arm or an audio sample. A sample
// passes the accept, activate and check steps of frame bookkeeping, then
// each output in use yields one beat through read, gain, scale and output
// steps; while a ramp runs, a multiply and the bit-serial restoring divider
// (21 quotient bits, one per cycle) that forms the interpolated gain come
// between read and gain. A sample outside the active block gives no beats.
// The input is stalled only while a sample is being worked.
// The output register holds a beat until it is taken; while the receiver
// stalls, the sequencer waits in its output step and nothing is lost.
// Reset (rst_n low, synchronous) clears the frame counter, all gain sets and
// block state, sets num_outputs to 2 and the default ramp to 0. Configuration
// writes take effect at once; the user must make them while idle, unchecked.
// ---------------------------------------------------------------------------
module gain_ramp_channel_mixer
  import grcm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_idx,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_beat_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_beat_t        out_data
);

  cmd_t  cmd;
  stat_t stat;

  grcm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_data.action),
    .in_stall  (in_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  grcm_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

FILE: tb/grcm_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// grcm_checker
// Predicts and checks the output beats of the gain ramp channel mixer.
// ---------------------------------------------------------------------------
// Watches the register port and both channels. Every accepted input beat
// updates a private copy of the mixer state and queues the contributions it
// should produce; every accepted output beat is compared with the oldest one.
// ---------------------------------------------------------------------------
module grcm_checker
  import grcm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_idx,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  input  logic             in_stall,
  input  in_beat_t         in_data,
  input  logic             out_valid,
  input  logic             out_stall,
  input  out_beat_t        out_data,
  output int               errors,
  output int               pending,
  output int               mixed_beats
);

  // Mirror of the mixer state.
  logic [CNT_W-1:0]         n_outputs;
  logic [RAMP_W-1:0]        dflt_ramp;
  logic [FRAME_BITS-1:0]    frame;
  logic signed [GAIN_W-1:0] cur_dir[MAX_OUTPUTS];
  logic signed [GAIN_W-1:0] cur_dif[MAX_OUTPUTS];
  logic signed [GAIN_W-1:0] prev_dir[MAX_OUTPUTS];
  logic signed [GAIN_W-1:0] prev_dif[MAX_OUTPUTS];
  logic signed [GAIN_W-1:0] pend_dir[MAX_OUTPUTS];
  logic signed [GAIN_W-1:0] pend_dif[MAX_OUTPUTS];
  logic [FRAME_BITS-1:0]    blk_start, blk_end, pend_start, pend_end;
  logic [RAMP_W-1:0]        blk_ramp, pend_ramp;
  logic                     pend_jump, pend_armed, any_block;

  out_beat_t mix_q[$];

  assign pending = mix_q.size();

  // Interpolated gain, rounded half away from zero.
  function automatic logic signed [GAIN_W-1:0] ramped_gain(
      logic signed [GAIN_W-1:0] from_g, logic signed [GAIN_W-1:0] to_g,
      longint delta, longint len);
    longint num, mag, q;
    num = (longint'(to_g) - longint'(from_g)) * delta;
    mag = (num < 0) ? -num : num;
    q   = (mag + len / 2) / len;
    return GAIN_W'(longint'(from_g) + ((num < 0) ? -q : q));
  endfunction

  // Sample times gain, rounded half up and saturated to Q1.23.
  function automatic logic signed [SAMP_W-1:0] scaled(
      logic signed [SAMP_W-1:0] s, logic signed [GAIN_W-1:0] g);
    longint r;
    r = (longint'(s) * longint'(g) + 32768) >>> 16;
    if (r > 8388607) r = 8388607;
    if (r < -8388608) r = -8388608;
    return SAMP_W'(r);
  endfunction

  task automatic reset_mirror();
    n_outputs  = 2;
    dflt_ramp  = '0;
    frame      = '0;
    for (int i = 0; i < MAX_OUTPUTS; i++) begin
      cur_dir[i] = '0; cur_dif[i] = '0; prev_dir[i] = '0;
      prev_dif[i] = '0; pend_dir[i] = '0; pend_dif[i] = '0;
    end
    blk_start  = '0; blk_end = '0; blk_ramp = '0;
    pend_start = '0; pend_end = '0; pend_ramp = '0;
    pend_jump  = 1'b0; pend_armed = 1'b0; any_block = 1'b0;
  endtask

  // Advance the mirror by one input beat and queue its contributions.
  task automatic mix_beat(in_beat_t b);
    logic [FRAME_BITS-1:0] t, span, delta;
    logic signed [GAIN_W-1:0] gd, gf;
    int n;
    logic ramping;
    out_beat_t o;
    case (b.action)
      ACT_LOAD: begin
        pend_dir[b.out_index] = b.direct_gain;
        pend_dif[b.out_index] = b.diffuse_gain;
      end
      ACT_ARM: begin
        pend_start = b.start_frame;
        pend_end   = b.end_frame;
        pend_jump  = b.jump;
        pend_ramp  = b.ramp_given ? b.ramp_samples : dflt_ramp;
        pend_armed = 1'b1;
      end
      ACT_SAMPLE: begin
        t = frame;
        frame = frame + 1'b1;
        // A pending block takes over once its start frame is reached.
        if (pend_armed && t >= pend_start) begin
          for (int i = 0; i < MAX_OUTPUTS; i++) begin
            prev_dir[i] = cur_dir[i]; prev_dif[i] = cur_dif[i];
            cur_dir[i]  = pend_dir[i]; cur_dif[i] = pend_dif[i];
          end
          blk_start = pend_start;
          blk_end   = pend_end;
          span = (blk_end > blk_start) ? blk_end - blk_start : '0;
          if (pend_jump || !any_block) blk_ramp = '0;
          else blk_ramp = (FRAME_BITS'(pend_ramp) < span) ? pend_ramp : RAMP_W'(span);
          any_block  = 1'b1;
          pend_armed = 1'b0;
        end
        if (any_block && t >= blk_start && (blk_end == NEVER_END || t < blk_end)) begin
          n = (n_outputs > MAX_OUTPUTS) ? MAX_OUTPUTS : int'(n_outputs);
          delta = t - blk_start;
          ramping = (blk_ramp != 0) && (delta < FRAME_BITS'(blk_ramp));
          for (int k = 0; k < n; k++) begin
            gd = cur_dir[k];
            gf = cur_dif[k];
            if (ramping) begin
              gd = ramped_gain(prev_dir[k], gd, longint'(delta), longint'(blk_ramp));
              gf = ramped_gain(prev_dif[k], gf, longint'(delta), longint'(blk_ramp));
            end
            o.channel      = CH_W'(k);
            o.direct_part  = scaled(b.sample, gd);
            o.diffuse_part = scaled(b.sample, gf);
            o.last         = (k + 1 == n);
            mix_q = {mix_q, o};
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      reset_mirror();
      mix_q.delete();
      errors      <= 0;
      mixed_beats <= 0;
    end else begin
      // Compare first: a result never belongs to the beat accepted at this edge.
      if (out_valid && !out_stall) begin
        mixed_beats <= mixed_beats + 1;
        if (mix_q.size() == 0) begin
          $display("%0t: unexpected output beat %p", $time, out_data);
          errors <= errors + 1;
        end else begin
          want = mix_q.pop_front();
          if (want.channel !== out_data.channel ||
              want.direct_part !== out_data.direct_part ||
              want.diffuse_part !== out_data.diffuse_part ||
              want.last !== out_data.last) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, out_data);
            errors <= errors + 1;
          end
        end
      end
      if (cfg_we) begin
        if (cfg_idx == CFG_NUM_OUTPUTS) n_outputs = cfg_data[CNT_W-1:0];
        else dflt_ramp = cfg_data[RAMP_W-1:0];
      end
      if (in_valid && !in_stall) mix_beat(in_data);
    end
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the gain ramp channel mixer.
// ---------------------------------------------------------------------------
// Drives a directed opening (gain extremes, saturation, first block, ramps,
// jumps, late and re-arms, empty blocks) and then random block sequences
// mixed with noise beats, under bursty input and patterned output stalls.
// Register writes happen only once the mixer has drained.
// ---------------------------------------------------------------------------
module tb_top;
  import grcm_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int HOLD_OFF   = 64;
  localparam int IN_W       = $bits(in_beat_t);

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic             cfg_idx;
  logic [CFG_W-1:0] cfg_data;
  logic             in_valid;
  logic             in_stall;
  in_beat_t         in_data;
  logic             out_valid;
  logic             out_stall;
  out_beat_t        out_data;
  int               errors, pending, mixed_beats;

  int               beats_sent, samples_sent, reg_writes, burst_left;
  logic [FRAME_BITS-1:0] frame_now;

  gain_ramp_channel_mixer dut (.*);

  grcm_checker chk (
    .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_data, .in_valid, .in_stall,
    .in_data, .out_valid, .out_stall, .out_data,
    .errors, .pending, .mixed_beats
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver stalls in modes that are picked at random.
  int stall_mode, stall_cnt;
  initial begin
    out_stall = 1'b0;
    stall_mode = 0;
    stall_cnt = 0;
  end
  always @(posedge clk) begin
    if (stall_cnt == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_cnt = 64;
    end
    stall_cnt--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= $urandom_range(0, 1);
      default: out_stall <= (stall_cnt % 16) < 11;
    endcase
  end

  // Watchdog on cycles without any beat moving.
  int idle_cycles;
  initial idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Send one beat and wait for it to be taken; bursts end in a random gap.
  task automatic send(in_beat_t b);
    in_data  <= b;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (b.action != ACT_NOP) beats_sent++;
    if (b.action == ACT_SAMPLE) begin
      samples_sent++;
      frame_now++;
    end
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      burst_left = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(0, 8);
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  // Hold the input until every expected beat has come, then let it settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (HOLD_OFF) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
    drain();
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we   <= 1'b0;
    reg_writes++;
  endtask

  task automatic load(int idx, int dg, int fg);
    in_beat_t b;
    b = '0;
    b.action = ACT_LOAD;
    b.out_index = CH_W'(idx);
    b.direct_gain = GAIN_W'(dg);
    b.diffuse_gain = GAIN_W'(fg);
    b.start_frame = FRAME_BITS'({$urandom, $urandom});
    send(b);
  endtask

  task automatic arm(logic [FRAME_BITS-1:0] st, logic [FRAME_BITS-1:0] en,
                     logic jmp, logic given, int ramp);
    in_beat_t b;
    b = '0;
    b.action = ACT_ARM;
    b.start_frame = st;
    b.end_frame = en;
    b.jump = jmp;
    b.ramp_given = given;
    b.ramp_samples = RAMP_W'(ramp);
    b.sample = SAMP_W'($urandom);
    send(b);
  endtask

  task automatic sample(int s);
    in_beat_t b;
    b = '0;
    b.action = ACT_SAMPLE;
    b.sample = SAMP_W'(s);
    b.out_index = CH_W'($urandom);
    send(b);
  endtask

  function automatic int rand_audio();
    case ($urandom_range(0, 5))
      0: return 8388607;
      1: return -8388608;
      default: return int'($urandom) >>> 8;
    endcase
  endfunction

  function automatic int rand_gain();
    case ($urandom_range(0, 5))
      0: return 524287;
      1: return -524288;
      default: return int'($urandom) >>> 12;
    endcase
  endfunction

  initial begin
    in_beat_t b;
    logic [FRAME_BITS-1:0] st, en;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_NUM_OUTPUTS;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    beats_sent = 0;
    samples_sent = 0;
    reg_writes = 0;
    burst_left = 0;
    frame_now = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening: extremes, first block without ramp, saturation.
    write_reg(CFG_NUM_OUTPUTS, CFG_W'(3));
    sample(12345);
    load(0, 524287, -524288);
    load(1, -524288, 524287);
    load(2, 65536, -65536);
    load(31, -1, -1);
    arm(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b1, 20'hFFFFF);
    arm(0, NEVER_END, 1'b0, 1'b0, 0);
    sample(8388607);
    sample(-8388608);
    sample(0);
    sample(-1);
    b = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    b.action = ACT_NOP;
    send(b);
    // Ramped block that ends, then a jump, then an empty block.
    load(0, -524288, 524287);
    arm(frame_now + 1, frame_now + 8, 1'b0, 1'b1, 5);
    repeat (10) sample(rand_audio());
    arm(frame_now, frame_now + 3, 1'b1, 1'b1, 3);
    repeat (2) sample(8388607);
    arm(frame_now, frame_now, 1'b0, 1'b1, 4);
    sample(1);

    // Random block sequences with noise in between.
    while (beats_sent < 350) begin
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 4))
          0: write_reg(CFG_NUM_OUTPUTS, CFG_W'(0));
          1: write_reg(CFG_NUM_OUTPUTS, CFG_W'($urandom_range(32, 63)));
          default: write_reg(CFG_NUM_OUTPUTS, CFG_W'($urandom_range(1, 6)));
        endcase
        write_reg(CFG_DEFAULT_RAMP, CFG_W'(($urandom_range(0, 5) == 0) ? 20'hFFFFF
                                                                     : $urandom_range(0, 12)));
      end
      if ($urandom_range(0, 4) == 0) begin
        b = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        send(b);
      end else begin
        repeat ($urandom_range(0, 6)) load($urandom_range(0, 31), rand_gain(), rand_gain());
        st = frame_now + $urandom_range(0, 4);
        if ($urandom_range(0, 5) == 0) st = frame_now - $urandom_range(1, 6);
        case ($urandom_range(0, 5))
          0: en = NEVER_END;
          1: en = FRAME_BITS'({$urandom, $urandom});
          default: en = st + $urandom_range(1, 16);
        endcase
        arm(st, en, $urandom_range(0, 9) == 0, 1'($urandom_range(0, 1)),
            ($urandom_range(0, 7) == 0) ? int'($urandom) : $urandom_range(0, 16));
        repeat ($urandom_range(1, 12)) sample(rand_audio());
      end
    end

    drain();
    repeat (100) @(posedge clk);
    $display("Sent %0d beats (%0d samples) with %0d register writes;", beats_sent,
             samples_sent, reg_writes);
    $display("checked %0d output contributions.", mixed_beats);
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/grcm_pkg.sv
rtl/grcm_ctrl.sv
rtl/grcm_dpath.sv
rtl/gain_ramp_channel_mixer.sv
tb/grcm_checker.sv
tb/tb_top.sv
